/* rtl/core/ssl_pkg.sv */
// ----------------------------------------------------------------------------
// ssl_pkg: shared definitions for the scaled sine lookup unit
// Quarter-wave sine table, table geometry and the control bits that travel
// down the lookup pipeline.
// ----------------------------------------------------------------------------
package ssl_pkg;

    // Table geometry: one quarter wave, 256 positions of 16 bits
    localparam int TBL_DEPTH = 256;
    localparam int TBL_AW    = 8;
    localparam int SMP_W     = 16;

    // Phase split: bits 14..6 position, bits 5..0 fraction, bit 15 sign
    localparam int FRAC_W    = 6;
    localparam int POS_W     = 9;

    // Position of the quarter point, where the result is the amplitude itself
    localparam logic [POS_W-1:0] POS_QUARTER = 9'd256;
    // Last table entry, where no next entry exists to interpolate toward
    localparam logic [TBL_AW-1:0] POS_LAST   = 8'd255;
    // Fraction at or above half a step snaps the last entry to full scale
    localparam logic [FRAC_W:0]  FRAC_HALF   = 7'd32;
    localparam logic [FRAC_W:0]  FRAC_FULL   = 7'd64;

    // Control bits carried along with each request
    typedef struct packed {
        logic force_amp;   // result is +/- amplitude exactly
        logic negate;      // phase in the second half turn
        logic last_entry;  // entry 255: no interpolation
    } stage_ctrl_t;

    // round(65536 * sin(i/256 * pi/2)), clipped to 65535
    localparam logic [SMP_W-1:0] QW_TABLE [0:TBL_DEPTH-1] = '{
        16'd0,     16'd402,   16'd804,   16'd1206,  16'd1608,  16'd2010,  16'd2412,  16'd2814,
        16'd3216,  16'd3617,  16'd4019,  16'd4420,  16'd4821,  16'd5222,  16'd5623,  16'd6023,
        16'd6424,  16'd6824,  16'd7224,  16'd7623,  16'd8022,  16'd8421,  16'd8820,  16'd9218,
        16'd9616,  16'd10014, 16'd10411, 16'd10808, 16'd11204, 16'd11600, 16'd11996, 16'd12391,
        16'd12785, 16'd13180, 16'd13573, 16'd13966, 16'd14359, 16'd14751, 16'd15143, 16'd15534,
        16'd15924, 16'd16314, 16'd16703, 16'd17091, 16'd17479, 16'd17867, 16'd18253, 16'd18639,
        16'd19024, 16'd19409, 16'd19792, 16'd20175, 16'd20557, 16'd20939, 16'd21320, 16'd21699,
        16'd22078, 16'd22457, 16'd22834, 16'd23210, 16'd23586, 16'd23961, 16'd24335, 16'd24708,
        16'd25080, 16'd25451, 16'd25821, 16'd26190, 16'd26558, 16'd26925, 16'd27291, 16'd27656,
        16'd28020, 16'd28383, 16'd28745, 16'd29106, 16'd29466, 16'd29824, 16'd30182, 16'd30538,
        16'd30893, 16'd31248, 16'd31600, 16'd31952, 16'd32303, 16'd32652, 16'd33000, 16'd33347,
        16'd33692, 16'd34037, 16'd34380, 16'd34721, 16'd35062, 16'd35401, 16'd35738, 16'd36075,
        16'd36410, 16'd36744, 16'd37076, 16'd37407, 16'd37736, 16'd38064, 16'd38391, 16'd38716,
        16'd39040, 16'd39362, 16'd39683, 16'd40002, 16'd40320, 16'd40636, 16'd40951, 16'd41264,
        16'd41576, 16'd41886, 16'd42194, 16'd42501, 16'd42806, 16'd43110, 16'd43412, 16'd43713,
        16'd44011, 16'd44308, 16'd44604, 16'd44898, 16'd45190, 16'd45480, 16'd45769, 16'd46056,
        16'd46341, 16'd46624, 16'd46906, 16'd47186, 16'd47464, 16'd47741, 16'd48015, 16'd48288,
        16'd48559, 16'd48828, 16'd49095, 16'd49361, 16'd49624, 16'd49886, 16'd50146, 16'd50404,
        16'd50660, 16'd50914, 16'd51166, 16'd51417, 16'd51665, 16'd51911, 16'd52156, 16'd52398,
        16'd52639, 16'd52878, 16'd53114, 16'd53349, 16'd53581, 16'd53812, 16'd54040, 16'd54267,
        16'd54491, 16'd54714, 16'd54934, 16'd55152, 16'd55368, 16'd55582, 16'd55794, 16'd56004,
        16'd56212, 16'd56418, 16'd56621, 16'd56823, 16'd57022, 16'd57219, 16'd57414, 16'd57607,
        16'd57798, 16'd57986, 16'd58172, 16'd58356, 16'd58538, 16'd58718, 16'd58896, 16'd59071,
        16'd59244, 16'd59415, 16'd59583, 16'd59750, 16'd59914, 16'd60075, 16'd60235, 16'd60392,
        16'd60547, 16'd60700, 16'd60851, 16'd60999, 16'd61145, 16'd61288, 16'd61429, 16'd61568,
        16'd61705, 16'd61839, 16'd61971, 16'd62101, 16'd62228, 16'd62353, 16'd62476, 16'd62596,
        16'd62714, 16'd62830, 16'd62943, 16'd63054, 16'd63162, 16'd63268, 16'd63372, 16'd63473,
        16'd63572, 16'd63668, 16'd63763, 16'd63854, 16'd63944, 16'd64031, 16'd64115, 16'd64197,
        16'd64277, 16'd64354, 16'd64429, 16'd64501, 16'd64571, 16'd64639, 16'd64704, 16'd64766,
        16'd64827, 16'd64884, 16'd64940, 16'd64993, 16'd65043, 16'd65091, 16'd65137, 16'd65180,
        16'd65220, 16'd65259, 16'd65294, 16'd65328, 16'd65358, 16'd65387, 16'd65413, 16'd65436,
        16'd65457, 16'd65476, 16'd65492, 16'd65505, 16'd65516, 16'd65525, 16'd65531, 16'd65535
    };

endpackage

/* rtl/core/scaled_sine_lookup_unit.sv */
// ----------------------------------------------------------------------------
// scaled_sine_lookup_unit: amplitude times sine of phase
// Quarter-wave table in RAM with linear interpolation between neighboring
// entries, a signed scale multiply, rounding and sign from the top phase bit.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   request | s_valid s_ready s_phase        | in
//           | s_amplitude                    |
//   result  | m_valid m_ready m_sine_value   | out
//
// One request per cycle sustained while m_ready stays high; each passes through
// the RAM read, interpolation multiply, interpolation add, scale multiply, and
// round and sign into the output register.
// After reset the table RAM is loaded from the constant table, one entry per
// cycle, and s_ready stays low until all 256 entries are written.
// Stages advance independently, so bubbles collapse and new requests are
// taken while a finished result waits on m_ready.
// ----------------------------------------------------------------------------
module scaled_sine_lookup_unit import ssl_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [SMP_W-1:0]        s_phase,
    input  logic signed [SMP_W-1:0] s_amplitude,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [SMP_W-1:0] m_sine_value
);

    // ------------------------------------------------------------------
    // Table load sequencer
    // ------------------------------------------------------------------
    logic [TBL_AW:0]   fill_cnt_reg, fill_cnt_next;
    logic              fill_done;
    logic [TBL_AW-1:0] fill_addr, fill_addr_inc;
    logic [2*SMP_W-1:0] fill_data;

    assign fill_done     = fill_cnt_reg[TBL_AW];
    assign fill_addr     = fill_cnt_reg[TBL_AW-1:0];
    assign fill_addr_inc = fill_addr + TBL_AW'(1);
    // Each word pairs an entry with its successor: {next, this}
    assign fill_data     = {QW_TABLE[fill_addr_inc], QW_TABLE[fill_addr]};
    assign fill_cnt_next = fill_done ? fill_cnt_reg : fill_cnt_reg + (TBL_AW+1)'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg <= '0;
        end else begin
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage enables: a stage loads when empty or when its successor moves
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, m_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next, m_valid_next;
    logic out_en, s4_en, s3_en, s2_en, s1_en;
    logic in_fire;

    assign out_en  = !m_valid_reg || m_ready;
    assign s4_en   = !s4_valid_reg || out_en;
    assign s3_en   = !s3_valid_reg || s4_en;
    assign s2_en   = !s2_valid_reg || s3_en;
    assign s1_en   = !s1_valid_reg || s2_en;
    assign s_ready = fill_done && s1_en;
    assign in_fire = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Stage 0: mirror the position, flag the exact-amplitude cases
    // ------------------------------------------------------------------
    logic [POS_W-1:0]  pos_raw;
    logic [FRAC_W-1:0] frac_raw;
    logic [POS_W:0]    pos_mirror;
    logic [TBL_AW-1:0] pos_addr;
    logic [FRAC_W:0]   frac_eff;
    stage_ctrl_t       s0_ctrl;

    assign pos_raw    = s_phase[14:6];
    assign frac_raw   = s_phase[FRAC_W-1:0];
    assign pos_mirror = (POS_W+1)'(512) - {1'b0, pos_raw};

    always_comb begin
        if (pos_raw > POS_QUARTER) begin
            pos_addr = pos_mirror[TBL_AW-1:0];
            frac_eff = FRAC_FULL - {1'b0, frac_raw};
        end else begin
            pos_addr = pos_raw[TBL_AW-1:0];
            frac_eff = {1'b0, frac_raw};
        end
        s0_ctrl.negate     = s_phase[15];
        s0_ctrl.last_entry = (pos_addr == POS_LAST);
        s0_ctrl.force_amp  = (pos_raw == POS_QUARTER)
                          || ((pos_addr == POS_LAST) && (frac_eff >= FRAC_HALF));
    end

    // ------------------------------------------------------------------
    // Table RAM: loader writes, stage 1 reads
    // ------------------------------------------------------------------
    logic [2*SMP_W-1:0] tbl_rd_data;

    ssl_ram #(
        .WIDTH (2*SMP_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .clk     (aclk),
        .wr_en   (!fill_done),
        .wr_addr (fill_addr),
        .wr_data (fill_data),
        .rd_en   (s1_en),
        .rd_addr (pos_addr),
        .rd_data (tbl_rd_data)
    );

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    always_comb begin
        s1_valid_next = s1_en  ? in_fire      : s1_valid_reg;
        s2_valid_next = s2_en  ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_en  ? s2_valid_reg : s3_valid_reg;
        s4_valid_next = s4_en  ? s3_valid_reg : s4_valid_reg;
        m_valid_next  = out_en ? s4_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    stage_ctrl_t              s1_ctrl_reg, s2_ctrl_reg, s3_ctrl_reg, s4_ctrl_reg;
    logic [FRAC_W:0]          s1_frac_reg;
    logic signed [SMP_W-1:0]  s1_amp_reg, s2_amp_reg, s3_amp_reg, s4_amp_reg;
    logic [SMP_W-1:0]         s2_tv_reg, s3_tv_reg, s3_tv_next;
    logic [SMP_W+FRAC_W:0]    s2_prod_reg, s2_prod_next, s3_round;
    logic [SMP_W-1:0]         s2_tv_cur, s2_tv_nxt, s2_diff;
    logic signed [2*SMP_W:0]  s4_prod_reg, s4_prod_next;
    logic [2*SMP_W-1:0]       out_round;
    logic [SMP_W-1:0]         out_mag, out_val;
    logic signed [SMP_W-1:0]  m_sine_value_reg, m_sine_value_next;

    // Stage 2: step to the next entry times the fraction
    assign s2_tv_cur    = tbl_rd_data[SMP_W-1:0];
    assign s2_tv_nxt    = tbl_rd_data[2*SMP_W-1:SMP_W];
    assign s2_diff      = s1_ctrl_reg.last_entry ? '0 : s2_tv_nxt - s2_tv_cur;
    assign s2_prod_next = {{(FRAC_W+1){1'b0}}, s2_diff} * {{SMP_W{1'b0}}, s1_frac_reg};

    // Stage 3: add the rounded interpolation step
    assign s3_round   = s2_prod_reg + (SMP_W+FRAC_W+1)'(32);
    assign s3_tv_next = s2_tv_reg + s3_round[SMP_W+FRAC_W-1:FRAC_W];

    // Stage 4: scale by the signed amplitude
    assign s4_prod_next = $signed({1'b0, s3_tv_reg}) * s3_amp_reg;

    // Output: round half up, pick exact amplitude, apply sign with wrap
    assign out_round = s4_prod_reg[2*SMP_W-1:0] + (2*SMP_W)'(32768);
    assign out_mag   = s4_ctrl_reg.force_amp ? s4_amp_reg : out_round[2*SMP_W-1:SMP_W];
    assign out_val   = s4_ctrl_reg.negate ? SMP_W'(0) - out_mag : out_mag;
    assign m_sine_value_next = out_val;

    always_ff @(posedge aclk) begin
        if (s1_en) begin
            s1_ctrl_reg <= s0_ctrl;
            s1_frac_reg <= frac_eff;
            s1_amp_reg  <= s_amplitude;
        end
        if (s2_en) begin
            s2_ctrl_reg <= s1_ctrl_reg;
            s2_amp_reg  <= s1_amp_reg;
            s2_tv_reg   <= s2_tv_cur;
            s2_prod_reg <= s2_prod_next;
        end
        if (s3_en) begin
            s3_ctrl_reg <= s2_ctrl_reg;
            s3_amp_reg  <= s2_amp_reg;
            s3_tv_reg   <= s3_tv_next;
        end
        if (s4_en) begin
            s4_ctrl_reg <= s3_ctrl_reg;
            s4_amp_reg  <= s3_amp_reg;
            s4_prod_reg <= s4_prod_next;
        end
        if (out_en) begin
            m_sine_value_reg <= m_sine_value_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sine_value = m_sine_value_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // No request is taken while the table is still loading
    assert property (@(posedge aclk) disable iff (!aresetn)
        !fill_done |-> !s_ready)
        else $error("request accepted during table load");

    // No result can appear before the table load completes
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg || s1_valid_reg) |-> fill_done)
        else $error("pipeline occupied before table load done");

    // An accepted request always lands in stage 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> s1_valid_reg)
        else $error("accepted request lost at stage 1");

    // The quarter point always takes the exact-amplitude path
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (s_phase[14:6] == POS_QUARTER)) |=> s1_ctrl_reg.force_amp)
        else $error("quarter point not flagged as exact amplitude");

    // A stalled result register holds back stage 4
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && s4_valid_reg) |=> (s4_valid_reg && m_valid_reg))
        else $error("stage 4 dropped while output stalled");

endmodule

/* rtl/core/ssl_ram.sv */
// ----------------------------------------------------------------------------
// ssl_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ssl_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port; hold data when not enabled
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
